// File: rtl/core/mcpd_pkg.sv
// ----------------------------------------------------------------------------
// mcpd_pkg: shared types and constants of the motor command pi drive
// widths, register indexes, reset values, mode codes and shared structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcpd_pkg;

  localparam int unsigned DRIVE_W    = 12;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned SCALE_W    = 6;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned INTEG_W    = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [DRIVE_W-1:0] MAX_OUTPUT_RST        = 12'd3100;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST    = 15'd1000;
  localparam logic [GAIN_W-1:0]  PROPORTIONAL_GAIN_RST = 12'd530;
  localparam logic [SCALE_W-1:0] DUTY_SCALE_RST        = 6'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_OUTPUT        = 2'd0,
    REG_INTEGRAL_LIMIT    = 2'd1,
    REG_PROPORTIONAL_GAIN = 2'd2,
    REG_DUTY_SCALE        = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_DUTY     = 2'd1,
    MODE_POSITION = 2'd2,
    MODE_RESERVE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] max_output;
    logic [LIMIT_W-1:0] integral_limit;
    logic [GAIN_W-1:0]  proportional_gain;
    logic [SCALE_W-1:0] duty_scale;
  } cfg_regs_t;

  typedef struct packed {
    logic [DRIVE_W-1:0]        forward;
    logic [DRIVE_W-1:0]        reverse;
    logic signed [INTEG_W-1:0] integral;
    logic                      clear;
  } law_res_t;

endpackage : mcpd_pkg

`default_nettype wire

// File: rtl/core/mcpd_crc_check.sv
// ----------------------------------------------------------------------------
// mcpd_crc_check: packet check
// crc-8, poly 0x8d, msb first, init 0, over the four command bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcpd_crc_check (
  input  wire logic [mcpd_pkg::BYTE_W-1:0] mode_byte,
  input  wire logic [mcpd_pkg::BYTE_W-1:0] flag_byte,
  input  wire logic [mcpd_pkg::BYTE_W-1:0] high_byte,
  input  wire logic [mcpd_pkg::BYTE_W-1:0] low_byte,
  input  wire logic [mcpd_pkg::BYTE_W-1:0] check_byte,
  output logic                             match
);
  import mcpd_pkg::*;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8D;

  // one byte through the shift register, eight bit steps
  function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] c_in);
    logic [BYTE_W-1:0] c;
    c = c_in;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[BYTE_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  logic [BYTE_W-1:0] crc0;
  logic [BYTE_W-1:0] crc1;
  logic [BYTE_W-1:0] crc2;
  logic [BYTE_W-1:0] crc3;

  assign crc0  = crc_byte(mode_byte);
  assign crc1  = crc_byte(crc0 ^ flag_byte);
  assign crc2  = crc_byte(crc1 ^ high_byte);
  assign crc3  = crc_byte(crc2 ^ low_byte);
  assign match = (crc3 == check_byte);

endmodule : mcpd_crc_check

`default_nettype wire

// File: rtl/core/mcpd_ctrl_law.sv
// ----------------------------------------------------------------------------
// mcpd_ctrl_law: control law for one tick
// runs the latched command: servo-off, duty, pi position or hold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcpd_ctrl_law (
  input  wire logic [mcpd_pkg::BYTE_W-1:0]         mode_byte,
  input  wire logic [mcpd_pkg::BYTE_W-1:0]         high_byte,
  input  wire logic [mcpd_pkg::BYTE_W-1:0]         low_byte,
  input  wire logic signed [mcpd_pkg::POS_W-1:0]   position,
  input  wire logic signed [mcpd_pkg::INTEG_W-1:0] integral,
  input  wire logic [mcpd_pkg::DRIVE_W-1:0]        forward,
  input  wire logic [mcpd_pkg::DRIVE_W-1:0]        reverse,
  input  wire mcpd_pkg::cfg_regs_t                 cfg,
  output mcpd_pkg::law_res_t                       res
);
  import mcpd_pkg::*;

  mode_t                    mode;
  logic                     ignore;
  logic signed [POS_W-1:0]  target;
  logic signed [POS_W:0]    err;
  logic signed [POS_W+1:0]  acc_sum;
  logic signed [POS_W+1:0]  lim_pos;
  logic signed [POS_W+1:0]  lim_neg;
  logic signed [POS_W+1:0]  acc_sat;
  logic signed [29:0]       prod;
  logic signed [31:0]       num;
  logic signed [31:0]       num_adj;
  logic signed [31:0]       pi_val;
  logic signed [14:0]       duty_val;
  logic signed [31:0]       v;
  logic [31:0]              v_abs;
  logic [DRIVE_W-1:0]       mag;
  logic [DRIVE_W-1:0]       drv_fwd;
  logic [DRIVE_W-1:0]       drv_rev;

  assign mode   = mode_t'(mode_byte[3:2]);
  assign ignore = mode_byte[1];
  assign target = $signed({high_byte, low_byte});

  // error at full precision, integral saturated at +/- limit
  assign err     = {target[POS_W-1], target} - {position[POS_W-1], position};
  assign acc_sum = {{2{integral[INTEG_W-1]}}, integral} + {err[POS_W], err};
  assign lim_pos = $signed({3'b000, cfg.integral_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (acc_sum > lim_pos) begin
      acc_sat = lim_pos;
    end else if (acc_sum < lim_neg) begin
      acc_sat = lim_neg;
    end else begin
      acc_sat = acc_sum;
    end
  end

  // (2*kp*err + integral) / 2, truncated toward zero
  assign prod    = $signed({1'b0, cfg.proportional_gain}) * err;
  assign num     = $signed({prod[29], prod, 1'b0}) + $signed({{14{acc_sat[POS_W+1]}}, acc_sat});
  assign num_adj = num + $signed({31'd0, num[31]});
  assign pi_val  = num_adj >>> 1;

  assign duty_val = $signed(low_byte) * $signed({1'b0, cfg.duty_scale});

  always_comb begin
    unique case (mode)
      MODE_DUTY:     v = {{17{duty_val[14]}}, duty_val};
      MODE_POSITION: v = pi_val;
      default:       v = 32'sd0;
    endcase
  end

  // clamp the magnitude and steer by sign
  assign v_abs = v[31] ? 32'(-v) : 32'(v);
  assign mag   = (v_abs > {20'd0, cfg.max_output}) ? cfg.max_output : v_abs[DRIVE_W-1:0];

  always_comb begin
    if (!v[31] && (v != 32'sd0)) begin
      drv_fwd = mag;
      drv_rev = '0;
    end else begin
      drv_fwd = '0;
      drv_rev = mag;
    end
  end

  always_comb begin
    res.forward  = forward;
    res.reverse  = reverse;
    res.integral = integral;
    res.clear    = 1'b0;
    if (!ignore) begin
      unique case (mode)
        MODE_OFF: begin
          res.forward = '0;
          res.reverse = '0;
          res.clear   = 1'b1;
        end
        MODE_DUTY: begin
          res.forward = drv_fwd;
          res.reverse = drv_rev;
        end
        MODE_POSITION: begin
          res.forward  = drv_fwd;
          res.reverse  = drv_rev;
          res.integral = acc_sat[INTEG_W-1:0];
        end
        MODE_RESERVE: begin
          res.clear = 1'b0;
        end
        default: begin
          res.clear = 1'b0;
        end
      endcase
    end
  end

endmodule : mcpd_ctrl_law

`default_nettype wire

// File: rtl/core/motor_command_pi_drive_core.sv
// ----------------------------------------------------------------------------
// motor_command_pi_drive_core: command latch and pi position drive
// packet check and latch, tick-driven servo-off / duty / pi control
// ----------------------------------------------------------------------------
// Every input item gives exactly one result item. A packet item (kind 1) is
// checked with crc-8 (poly 0x8d, init 0) over its four command bytes and on a
// match latches mode, high and low bytes; its result reports the acceptance
// and the drive levels now held. A tick item (kind 0) runs the latched
// command against the encoder position and reports the new drive levels and
// whether the encoder count should be cleared. The block is a two-register
// pipeline: an input register, then check / control-law logic (one 12x17
// multiply, add and clamp) into the result register, loaded when the item
// leaves the input register; it waits there while out_stall holds the result
// register; a new item is accepted every cycle while the result side keeps
// up. Configuration is written through cfg_we / cfg_index / cfg_wdata; the
// user must do so only while the block is idle (not enforced by the block).
`timescale 1ns / 1ps
`default_nettype none

module motor_command_pi_drive_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [mcpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mcpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_kind,
  input  wire logic signed [mcpd_pkg::POS_W-1:0]   in_position,
  input  wire logic [mcpd_pkg::BYTE_W-1:0]         in_mode_byte,
  input  wire logic [mcpd_pkg::BYTE_W-1:0]         in_flag_byte,
  input  wire logic [mcpd_pkg::BYTE_W-1:0]         in_high_byte,
  input  wire logic [mcpd_pkg::BYTE_W-1:0]         in_low_byte,
  input  wire logic [mcpd_pkg::BYTE_W-1:0]         in_check_byte,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_packet_accepted,
  output logic [mcpd_pkg::DRIVE_W-1:0]             out_drive_forward,
  output logic [mcpd_pkg::DRIVE_W-1:0]             out_drive_reverse,
  output logic                                     out_clear_position
);
  import mcpd_pkg::*;

  // configuration registers
  cfg_regs_t cfg_r;

  // input register
  logic                      s1_valid_r;
  logic                      s1_kind_r;
  logic signed [POS_W-1:0]   s1_position_r;
  logic [BYTE_W-1:0]         s1_mode_r;
  logic [BYTE_W-1:0]         s1_flag_r;
  logic [BYTE_W-1:0]         s1_high_r;
  logic [BYTE_W-1:0]         s1_low_r;
  logic [BYTE_W-1:0]         s1_check_r;

  // controller state
  logic [BYTE_W-1:0]         cmd_mode_r;
  logic [BYTE_W-1:0]         cmd_high_r;
  logic [BYTE_W-1:0]         cmd_low_r;
  logic signed [INTEG_W-1:0] integral_r;
  logic [DRIVE_W-1:0]        forward_r;
  logic [DRIVE_W-1:0]        reverse_r;

  // result register
  logic                      out_valid_r;
  logic                      out_accepted_r;
  logic [DRIVE_W-1:0]        out_forward_r;
  logic [DRIVE_W-1:0]        out_reverse_r;
  logic                      out_clear_r;

  logic                      advance;
  logic                      fire;
  logic                      in_take;
  logic                      crc_match;
  law_res_t                  law;

  // result register frees when empty or taken this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  mcpd_crc_check u_crc (
    .mode_byte  (s1_mode_r),
    .flag_byte  (s1_flag_r),
    .high_byte  (s1_high_r),
    .low_byte   (s1_low_r),
    .check_byte (s1_check_r),
    .match      (crc_match)
  );

  mcpd_ctrl_law u_law (
    .mode_byte (cmd_mode_r),
    .high_byte (cmd_high_r),
    .low_byte  (cmd_low_r),
    .position  (s1_position_r),
    .integral  (integral_r),
    .forward   (forward_r),
    .reverse   (reverse_r),
    .cfg       (cfg_r),
    .res       (law)
  );

  // configuration writes, masked to register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_output        <= MAX_OUTPUT_RST;
      cfg_r.integral_limit    <= INTEGRAL_LIMIT_RST;
      cfg_r.proportional_gain <= PROPORTIONAL_GAIN_RST;
      cfg_r.duty_scale        <= DUTY_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_OUTPUT:        cfg_r.max_output        <= cfg_wdata[DRIVE_W-1:0];
        REG_INTEGRAL_LIMIT:    cfg_r.integral_limit    <= cfg_wdata[LIMIT_W-1:0];
        REG_PROPORTIONAL_GAIN: cfg_r.proportional_gain <= cfg_wdata[GAIN_W-1:0];
        REG_DUTY_SCALE:        cfg_r.duty_scale        <= cfg_wdata[SCALE_W-1:0];
        default:               cfg_r.duty_scale        <= cfg_r.duty_scale;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r     <= in_kind;
      s1_position_r <= in_position;
      s1_mode_r     <= in_mode_byte;
      s1_flag_r     <= in_flag_byte;
      s1_high_r     <= in_high_byte;
      s1_low_r      <= in_low_byte;
      s1_check_r    <= in_check_byte;
    end
  end

  // controller state update, one item per fire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_mode_r <= '0;
      cmd_high_r <= '0;
      cmd_low_r  <= '0;
      integral_r <= '0;
      forward_r  <= '0;
      reverse_r  <= '0;
    end else if (fire) begin
      if (s1_kind_r) begin
        // packet: latch the command on a good check
        if (crc_match) begin
          cmd_mode_r <= s1_mode_r;
          cmd_high_r <= s1_high_r;
          cmd_low_r  <= s1_low_r;
        end
      end else begin
        // tick: run the latched command
        integral_r <= law.integral;
        forward_r  <= law.forward;
        reverse_r  <= law.reverse;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (s1_kind_r) begin
        out_accepted_r <= crc_match;
        out_forward_r  <= forward_r;
        out_reverse_r  <= reverse_r;
        out_clear_r    <= 1'b0;
      end else begin
        out_accepted_r <= 1'b0;
        out_forward_r  <= law.forward;
        out_reverse_r  <= law.reverse;
        out_clear_r    <= law.clear;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_packet_accepted = out_accepted_r;
  assign out_drive_forward   = out_forward_r;
  assign out_drive_reverse   = out_reverse_r;
  assign out_clear_position  = out_clear_r;

endmodule : motor_command_pi_drive_core

`default_nettype wire
